// ----- rtl/mas_pkg.sv -----
// shared types and constants for the motion alarm controller
package mas_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CountWidth = 16;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [TimeWidth-1:0]  TimeMax  = {TimeWidth{1'b1}};
    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] RegMotionThreshold  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegStableFrameCount = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegStableWindow     = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegPreDelay         = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegPostDelay        = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegMinTrigger       = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegMaxTrigger       = 3'd6;

    // register values after reset
    localparam logic [TimeWidth-1:0]  RstMotionThreshold  = 32'd1000;
    localparam logic [CountWidth-1:0] RstStableFrameCount = 16'd3;
    localparam logic [TimeWidth-1:0]  RstStableWindow     = 32'd1000000;
    localparam logic [TimeWidth-1:0]  RstPreDelay         = 32'd5;
    localparam logic [TimeWidth-1:0]  RstPostDelay        = 32'd5;
    localparam logic [TimeWidth-1:0]  RstMinTrigger       = 32'd5;
    localparam logic [TimeWidth-1:0]  RstMaxTrigger       = 32'd60;

    // input opcodes
    localparam logic OpFrame = 1'b0;
    localparam logic OpReset = 1'b1;

    typedef struct packed {
        logic [TimeWidth-1:0]  motion_threshold;
        logic [CountWidth-1:0] stable_frame_count;
        logic [TimeWidth-1:0]  stable_window_ticks;
        logic [TimeWidth-1:0]  pre_delay_sec;
        logic [TimeWidth-1:0]  post_delay_sec;
        logic [TimeWidth-1:0]  min_trigger_sec;
        logic [TimeWidth-1:0]  max_trigger_sec;
    } cfg_t;

    typedef struct packed {
        logic                 opcode;
        logic [TimeWidth-1:0] now_seconds;
        logic [TimeWidth-1:0] now_fine;
        logic [TimeWidth-1:0] motion_level;
    } item_t;

    typedef struct packed {
        logic [1:0]            state_code;
        logic [TimeWidth-1:0]  segment_end;
        logic [CountWidth-1:0] motion_frames;
        logic [TimeWidth-1:0]  can_start_at;
    } result_t;

endpackage

// ----- rtl/motion_alarm_state_machine.sv -----
// motion alarm controller top level
//
// Frame event requests enter on the s_ channel (valid/ready) with an opcode,
// the coarse second count, the fine tick count and the motion level. Each
// request yields exactly one result on the m_ channel: the state after the
// request, the segment end second, the stable motion frame count and the
// second after which vigilance may resume. An opcode of one clears all
// alarm state and reports idle and zeros.
// A request passes through the input register, the state update and the
// result register on its way to m_valid; one request is taken every cycle
// while the receiver keeps m_ready high.
// When the receiver stalls, the result register holds and the input
// register keeps one more request; s_ready falls only when both are full.
// The cfg_ channel writes registers by index and is always ready; writes
// belong to times when no request is in flight.
// Reset (aresetn low at a clock edge) returns registers to their defaults,
// the machine to idle with zeroed times and both channels to empty.
module motion_alarm_state_machine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [mas_pkg::TimeWidth-1:0]   s_now_seconds,
    input  logic [mas_pkg::TimeWidth-1:0]   s_now_fine,
    input  logic [mas_pkg::TimeWidth-1:0]   s_motion_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_state_code,
    output logic [mas_pkg::TimeWidth-1:0]   m_segment_end,
    output logic [mas_pkg::CountWidth-1:0]  m_motion_frames,
    output logic [mas_pkg::TimeWidth-1:0]   m_can_start_at,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mas_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [mas_pkg::TimeWidth-1:0]   cfg_data
);
    import mas_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t result;

    assign s_item.opcode       = s_opcode;
    assign s_item.now_seconds  = s_now_seconds;
    assign s_item.now_fine     = s_now_fine;
    assign s_item.motion_level = s_motion_level;

    assign m_state_code    = result.state_code;
    assign m_segment_end   = result.segment_end;
    assign m_motion_frames = result.motion_frames;
    assign m_can_start_at  = result.can_start_at;

    mas_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mas_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mas_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

endmodule

// ----- rtl/mas_cfg_regs.sv -----
// configuration register file for the motion alarm controller
module mas_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mas_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [mas_pkg::TimeWidth-1:0]   cfg_data,
    output mas_pkg::cfg_t                cfg
);
    import mas_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motion_threshold    <= RstMotionThreshold;
            cfg_reg.stable_frame_count  <= RstStableFrameCount;
            cfg_reg.stable_window_ticks <= RstStableWindow;
            cfg_reg.pre_delay_sec       <= RstPreDelay;
            cfg_reg.post_delay_sec      <= RstPostDelay;
            cfg_reg.min_trigger_sec     <= RstMinTrigger;
            cfg_reg.max_trigger_sec     <= RstMaxTrigger;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegMotionThreshold:  cfg_reg.motion_threshold    <= cfg_data;
                RegStableFrameCount: cfg_reg.stable_frame_count  <= cfg_data[CountWidth-1:0];
                RegStableWindow:     cfg_reg.stable_window_ticks <= cfg_data;
                RegPreDelay:         cfg_reg.pre_delay_sec       <= cfg_data;
                RegPostDelay:        cfg_reg.post_delay_sec      <= cfg_data;
                RegMinTrigger:       cfg_reg.min_trigger_sec     <= cfg_data;
                RegMaxTrigger:       cfg_reg.max_trigger_sec     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/mas_in_reg.sv -----
// input register stage for frame event requests
module mas_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mas_pkg::item_t s_item,
    output logic           item_valid,
    output mas_pkg::item_t item,
    input  logic           item_take
);
    import mas_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // refill in the same cycle the held request moves on
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- rtl/mas_fsm.sv -----
// alarm state machine with its timing state and the result register
module mas_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  mas_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  mas_pkg::item_t   item,
    output logic             item_take,
    output logic             m_valid,
    input  logic             m_ready,
    output mas_pkg::result_t result
);
    import mas_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAITING,
        ST_VIGILANT,
        ST_TRIGGERED
    } fsm_state_t;

    fsm_state_t            state_reg, state_next;
    logic [TimeWidth-1:0]  resume_reg, resume_next;
    logic [TimeWidth-1:0]  tstart_reg, tstart_next;
    logic [TimeWidth-1:0]  tend_reg, tend_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [TimeWidth-1:0]  wstart_reg, wstart_next;
    logic                  m_valid_reg;
    result_t               result_reg;

    logic                  moving;
    logic [TimeWidth:0]    delay_sum;
    logic [TimeWidth-1:0]  delay_sat;
    logic [TimeWidth-1:0]  seg_base;
    logic [TimeWidth:0]    min_sum;
    logic [TimeWidth:0]    max_sum;
    logic [TimeWidth-1:0]  min_sat;
    logic [TimeWidth-1:0]  max_sat;
    logic [TimeWidth-1:0]  seg_limit;
    logic [TimeWidth-1:0]  wstart_eff;
    logic [TimeWidth-1:0]  elapsed;
    logic [CountWidth-1:0] count_inc;

    assign item_take = item_valid && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign result    = result_reg;

    assign moving = item.motion_level > cfg.motion_threshold;

    // resume time: pre delay from idle, post delay on segment expiry
    assign delay_sum = {1'b0, item.now_seconds}
                     + {1'b0, (state_reg == ST_IDLE) ? cfg.pre_delay_sec
                                                     : cfg.post_delay_sec};
    assign delay_sat = delay_sum[TimeWidth] ? TimeMax : delay_sum[TimeWidth-1:0];

    // a new segment starts now, an open one keeps its recorded start
    assign seg_base  = (state_reg == ST_VIGILANT) ? item.now_seconds : tstart_reg;
    assign min_sum   = {1'b0, item.now_seconds} + {1'b0, cfg.min_trigger_sec};
    assign max_sum   = {1'b0, seg_base} + {1'b0, cfg.max_trigger_sec};
    assign min_sat   = min_sum[TimeWidth] ? TimeMax : min_sum[TimeWidth-1:0];
    assign max_sat   = max_sum[TimeWidth] ? TimeMax : max_sum[TimeWidth-1:0];
    assign seg_limit = (min_sat < max_sat) ? min_sat : max_sat;

    assign wstart_eff = (count_reg == '0) ? item.now_fine : wstart_reg;
    assign elapsed    = item.now_fine - wstart_eff;
    assign count_inc  = (count_reg < CountMax) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        tstart_next = tstart_reg;
        tend_next   = tend_reg;
        count_next  = count_reg;
        wstart_next = wstart_reg;
        if (item.opcode == OpReset) begin
            state_next  = ST_IDLE;
            resume_next = '0;
            tstart_next = '0;
            tend_next   = '0;
            count_next  = '0;
            wstart_next = '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    resume_next = delay_sat;
                    state_next  = ST_WAITING;
                end
                ST_WAITING: begin
                    if (item.now_seconds > resume_reg) begin
                        state_next = ST_VIGILANT;
                    end
                end
                ST_VIGILANT: begin
                    if (moving) begin
                        if (elapsed < cfg.stable_window_ticks) begin
                            // a zero required count behaves as one
                            if (count_inc >= cfg.stable_frame_count) begin
                                count_next  = '0;
                                wstart_next = '0;
                                tstart_next = item.now_seconds;
                                tend_next   = seg_limit;
                                state_next  = ST_TRIGGERED;
                            end else begin
                                count_next  = count_inc;
                                wstart_next = wstart_eff;
                            end
                        end else begin
                            // window ran out: start over
                            count_next  = '0;
                            wstart_next = '0;
                            tend_next   = '0;
                        end
                    end
                end
                ST_TRIGGERED: begin
                    if (item.now_seconds > tend_reg) begin
                        resume_next = delay_sat;
                        state_next  = ST_WAITING;
                    end else if (moving) begin
                        tend_next = seg_limit;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            resume_reg  <= '0;
            tstart_reg  <= '0;
            tend_reg    <= '0;
            count_reg   <= '0;
            wstart_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (item_take) begin
                state_reg                <= state_next;
                resume_reg               <= resume_next;
                tstart_reg               <= tstart_next;
                tend_reg                 <= tend_next;
                count_reg                <= count_next;
                wstart_reg               <= wstart_next;
                result_reg.state_code    <= state_next;
                result_reg.segment_end   <= tend_next;
                result_reg.motion_frames <= count_next;
                result_reg.can_start_at  <= resume_next;
                m_valid_reg              <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/alarm_result_monitor.sv -----
`timescale 1ns / 1ps
// result monitor for the motion alarm controller: predicts every result and compares it
module alarm_result_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [mas_pkg::TimeWidth-1:0]   s_now_seconds,
    input  logic [mas_pkg::TimeWidth-1:0]   s_now_fine,
    input  logic [mas_pkg::TimeWidth-1:0]   s_motion_level,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_state_code,
    input  logic [mas_pkg::TimeWidth-1:0]   m_segment_end,
    input  logic [mas_pkg::CountWidth-1:0]  m_motion_frames,
    input  logic [mas_pkg::TimeWidth-1:0]   m_can_start_at,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mas_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [mas_pkg::TimeWidth-1:0]   cfg_data,
    output int                              fail_count,
    output int                              result_count,
    output int                              pending_count
);
    import mas_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAITING   = 2'd1,
        MODE_VIGILANT  = 2'd2,
        MODE_TRIGGERED = 2'd3
    } alarm_mode_e;

    cfg_t                  regs;
    alarm_mode_e           mode;
    logic [TimeWidth-1:0]  resume_at;
    logic [TimeWidth-1:0]  seg_start;
    logic [TimeWidth-1:0]  seg_end;
    logic [TimeWidth-1:0]  win_origin;
    logic [CountWidth-1:0] frames;

    result_t alarm_results[$];
    int      mismatches = 0;
    int      results_seen = 0;

    function automatic logic [TimeWidth-1:0] add_clamped(input logic [TimeWidth-1:0] a,
                                                         input logic [TimeWidth-1:0] b);
        logic [TimeWidth:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TimeWidth] ? TimeMax : sum[TimeWidth-1:0];
    endfunction

    // earlier of now plus the minimum and start plus the maximum
    function automatic logic [TimeWidth-1:0] segment_close(input logic [TimeWidth-1:0] now);
        logic [TimeWidth-1:0] by_min;
        logic [TimeWidth-1:0] by_max;
        by_min = add_clamped(now, regs.min_trigger_sec);
        by_max = add_clamped(seg_start, regs.max_trigger_sec);
        return (by_min < by_max) ? by_min : by_max;
    endfunction

    task automatic clear_alarm();
        mode = MODE_IDLE;
        resume_at = '0;
        seg_start = '0;
        seg_end = '0;
        frames = '0;
        win_origin = '0;
    endtask

    task automatic advance_alarm(input item_t req, output result_t res);
        logic                 moving;
        logic [TimeWidth-1:0] elapsed;
        moving = req.motion_level > regs.motion_threshold;
        if (req.opcode == OpReset) begin
            clear_alarm();
        end else begin
            case (mode)
                MODE_IDLE: begin
                    resume_at = add_clamped(req.now_seconds, regs.pre_delay_sec);
                    mode = MODE_WAITING;
                end
                MODE_WAITING: begin
                    if (req.now_seconds > resume_at) mode = MODE_VIGILANT;
                end
                MODE_VIGILANT: begin
                    if (moving) begin
                        if (frames == '0) win_origin = req.now_fine;
                        // fine clock wraps, so the distance is taken modulo 2^32
                        elapsed = req.now_fine - win_origin;
                        if (elapsed < regs.stable_window_ticks) begin
                            if (frames != CountMax) frames = frames + 1'b1;
                            if (frames >= regs.stable_frame_count) begin
                                frames = '0;
                                win_origin = '0;
                                seg_start = req.now_seconds;
                                seg_end = segment_close(req.now_seconds);
                                mode = MODE_TRIGGERED;
                            end
                        end else begin
                            win_origin = '0;
                            seg_end = '0;
                            frames = '0;
                        end
                    end
                end
                default: begin
                    if (req.now_seconds > seg_end) begin
                        resume_at = add_clamped(req.now_seconds, regs.post_delay_sec);
                        mode = MODE_WAITING;
                    end else if (moving) begin
                        seg_end = segment_close(req.now_seconds);
                    end
                end
            endcase
        end
        res.state_code = mode;
        res.segment_end = seg_end;
        res.motion_frames = frames;
        res.can_start_at = resume_at;
    endtask

    task automatic report_mismatch(input string what, input logic [TimeWidth-1:0] got,
                                   input logic [TimeWidth-1:0] want);
        mismatches++;
        $display("%0t result %0d: %s got %0h expected %0h", $time, results_seen, what, got,
                 want);
    endtask

    always @(posedge aclk) begin
        item_t   req;
        result_t want;
        if (!aresetn) begin
            regs.motion_threshold = RstMotionThreshold;
            regs.stable_frame_count = RstStableFrameCount;
            regs.stable_window_ticks = RstStableWindow;
            regs.pre_delay_sec = RstPreDelay;
            regs.post_delay_sec = RstPostDelay;
            regs.min_trigger_sec = RstMinTrigger;
            regs.max_trigger_sec = RstMaxTrigger;
            clear_alarm();
            alarm_results.delete();
        end else begin
            // results leave before this edge's request enters: the block is registered
            if (m_valid && m_ready) begin
                results_seen++;
                if (alarm_results.size() == 0) begin
                    report_mismatch("result with nothing expected, state",
                                    TimeWidth'(m_state_code), '0);
                end else begin
                    want = alarm_results.pop_front();
                    if (m_state_code !== want.state_code)
                        report_mismatch("state_code", TimeWidth'(m_state_code),
                                        TimeWidth'(want.state_code));
                    if (m_segment_end !== want.segment_end)
                        report_mismatch("segment_end", m_segment_end, want.segment_end);
                    if (m_motion_frames !== want.motion_frames)
                        report_mismatch("motion_frames", TimeWidth'(m_motion_frames),
                                        TimeWidth'(want.motion_frames));
                    if (m_can_start_at !== want.can_start_at)
                        report_mismatch("can_start_at", m_can_start_at, want.can_start_at);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    RegMotionThreshold:  regs.motion_threshold = cfg_data;
                    RegStableFrameCount: regs.stable_frame_count = cfg_data[CountWidth-1:0];
                    RegStableWindow:     regs.stable_window_ticks = cfg_data;
                    RegPreDelay:         regs.pre_delay_sec = cfg_data;
                    RegPostDelay:        regs.post_delay_sec = cfg_data;
                    RegMinTrigger:       regs.min_trigger_sec = cfg_data;
                    RegMaxTrigger:       regs.max_trigger_sec = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                req.opcode = s_opcode;
                req.now_seconds = s_now_seconds;
                req.now_fine = s_now_fine;
                req.motion_level = s_motion_level;
                advance_alarm(req, want);
                alarm_results.push_back(want);
            end
        end
        fail_count <= mismatches;
        result_count <= results_seen;
        pending_count <= alarm_results.size();
    end

endmodule

// ----- tb/tb_motion_alarm_state_machine.sv -----
`timescale 1ns / 1ps
// testbench top for the motion alarm controller: clock, reset, stimulus and verdict
module tb_motion_alarm_state_machine;
    import mas_pkg::*;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_opcode = OpFrame;
    logic [TimeWidth-1:0]   s_now_seconds = '0;
    logic [TimeWidth-1:0]   s_now_fine = '0;
    logic [TimeWidth-1:0]   s_motion_level = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_state_code;
    logic [TimeWidth-1:0]   m_segment_end;
    logic [CountWidth-1:0]  m_motion_frames;
    logic [TimeWidth-1:0]   m_can_start_at;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [TimeWidth-1:0]   cfg_data = '0;

    int fail_count;
    int result_count;
    int pending_count;

    int                   sent = 0;
    bit                   calm = 1'b0;
    int unsigned          ready_left = 0;
    cfg_t                 settings;
    logic [TimeWidth-1:0] clock_sec;
    logic [TimeWidth-1:0] clock_tick;

    motion_alarm_state_machine DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_now_seconds  (s_now_seconds),
        .s_now_fine     (s_now_fine),
        .s_motion_level (s_motion_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_state_code   (m_state_code),
        .m_segment_end  (m_segment_end),
        .m_motion_frames(m_motion_frames),
        .m_can_start_at (m_can_start_at),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    alarm_result_monitor result_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_now_seconds  (s_now_seconds),
        .s_now_fine     (s_now_fine),
        .s_motion_level (s_motion_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_state_code   (m_state_code),
        .m_segment_end  (m_segment_end),
        .m_motion_frames(m_motion_frames),
        .m_can_start_at (m_can_start_at),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .result_count   (result_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("tb_motion_alarm_state_machine NOT OK");
        $finish;
    end

    // receiver: stall bursts between ready runs
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (m_ready && $urandom_range(2, 0) == 0) begin
            m_ready <= 1'b0;
            ready_left <= $urandom_range(10, 0);
        end else begin
            m_ready <= 1'b1;
            ready_left <= $urandom_range(40, 0);
        end
    end

    // called at a clock edge; returns at the edge that takes the request
    task automatic send_request(input logic op, input logic [TimeWidth-1:0] sec,
                                input logic [TimeWidth-1:0] fine,
                                input logic [TimeWidth-1:0] level);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_now_seconds <= sec;
        s_now_fine <= fine;
        s_motion_level <= level;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic sender_pause();
        int unsigned gap;
        if (!calm && $urandom_range(4, 0) == 0) begin
            gap = $urandom_range(11, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_and_idle(input logic op, input logic [TimeWidth-1:0] sec,
                                 input logic [TimeWidth-1:0] fine,
                                 input logic [TimeWidth-1:0] level);
        send_request(op, sec, fine, level);
        sender_pause();
    endtask

    // hold off until every request has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (result_count != sent) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [TimeWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_settings(input cfg_t c);
        write_reg(RegMotionThreshold, c.motion_threshold);
        write_reg(RegStableFrameCount, {16'd0, c.stable_frame_count});
        write_reg(RegStableWindow, c.stable_window_ticks);
        write_reg(RegPreDelay, c.pre_delay_sec);
        write_reg(RegPostDelay, c.post_delay_sec);
        write_reg(RegMinTrigger, c.min_trigger_sec);
        write_reg(RegMaxTrigger, c.max_trigger_sec);
        cfg_valid <= 1'b0;
        settings = c;
    endtask

    // mostly an ordered stream of frames, now and then a stray request
    task automatic send_random_item();
        int unsigned          roll;
        int unsigned          spread;
        logic                 op;
        logic [TimeWidth-1:0] step;
        logic [TimeWidth-1:0] level;
        logic [TimeWidth-1:0] thr;
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
            op = ($urandom_range(3, 0) == 0) ? OpReset : OpFrame;
            send_request(op, $urandom, $urandom, $urandom);
        end else begin
            op = (roll < 9) ? OpReset : OpFrame;
            spread = $urandom_range(9, 0);
            if (spread < 6) step = '0;
            else if (spread < 9) step = 32'd1;
            else step = $urandom_range(6, 2);
            clock_sec = (clock_sec > TimeMax - step) ? TimeMax : clock_sec + step;
            spread = $urandom_range(9, 0);
            if (spread < 7) step = $urandom_range(settings.stable_window_ticks >> 2, 0);
            else if (spread < 9) step = $urandom_range(settings.stable_window_ticks, 0);
            else step = $urandom;
            clock_tick = clock_tick + step;
            thr = settings.motion_threshold;
            if (thr != TimeMax && $urandom_range(1, 0) == 1) level = $urandom_range(TimeMax, thr + 1);
            else level = $urandom_range(thr, 0);
            send_request(op, clock_sec, clock_tick, level);
        end
        sender_pause();
    endtask

    task automatic run_phase(input cfg_t c, input logic [TimeWidth-1:0] sec_base,
                             input int items);
        drain();
        write_settings(c);
        clock_sec = sec_base;
        clock_tick = $urandom;
        send_request(OpReset, clock_sec, clock_tick, '0);
        for (int n = 0; n < items; n++) send_random_item();
    endtask

    initial begin
        cfg_t                 plan;
        logic [TimeWidth-1:0] base;
        int                   items;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: walk through every state
        send_and_idle(OpFrame, 32'd0, 32'd0, 32'd0);
        send_and_idle(OpFrame, 32'd5, 32'd0, 32'd0);
        send_and_idle(OpFrame, 32'd6, 32'd0, 32'd0);
        send_and_idle(OpFrame, 32'd6, 32'd100, 32'd1000);
        // window opens just before the fine clock wraps
        send_and_idle(OpFrame, 32'd6, 32'hFFFF_FF00, 32'd1001);
        send_and_idle(OpFrame, 32'd7, 32'h0000_0100, TimeMax);
        // motion outside the window clears the count
        send_and_idle(OpFrame, 32'd7, 32'd2_000_000, 32'd5000);
        send_and_idle(OpFrame, 32'd8, 32'd10, 32'd2000);
        send_and_idle(OpFrame, 32'd8, 32'd20, 32'd2000);
        send_and_idle(OpFrame, 32'd9, 32'd30, 32'd2000);
        send_and_idle(OpFrame, 32'd12, 32'd40, 32'd5000);
        send_and_idle(OpFrame, 32'd13, 32'd50, 32'd0);
        send_and_idle(OpFrame, 32'd17, 32'd60, 32'd0);
        send_and_idle(OpFrame, 32'd18, 32'd70, 32'd0);
        send_and_idle(OpReset, TimeMax, TimeMax, TimeMax);
        // resume time saturates
        send_and_idle(OpFrame, 32'hFFFF_FFFE, 32'd0, 32'd0);
        send_and_idle(OpFrame, TimeMax, 32'd0, 32'd0);
        send_and_idle(OpReset, 32'd0, 32'd0, 32'd0);

        // zero frame count and saturated segment bounds
        plan.motion_threshold = '0;
        plan.stable_frame_count = '0;
        plan.stable_window_ticks = TimeMax;
        plan.pre_delay_sec = '0;
        plan.post_delay_sec = '0;
        plan.min_trigger_sec = TimeMax;
        plan.max_trigger_sec = TimeMax;
        drain();
        write_settings(plan);
        send_and_idle(OpFrame, 32'd0, 32'd0, 32'd0);
        send_and_idle(OpFrame, 32'd1, 32'd0, 32'd1);
        send_and_idle(OpFrame, 32'd1, 32'd5, 32'd1);
        send_and_idle(OpFrame, 32'd100, 32'd9, 32'd0);
        send_and_idle(OpFrame, TimeMax, 32'd12, 32'd1);
        send_and_idle(OpReset, 32'd3, 32'd0, 32'd0);

        for (int p = 0; p < 6; p++) begin
            base = $urandom_range(1000, 0);
            case (p)
                0: begin
                    plan.motion_threshold = $urandom_range(2000, 0);
                    plan.stable_frame_count = $urandom_range(4, 1);
                    plan.stable_window_ticks = $urandom_range(50000, 1000);
                    plan.pre_delay_sec = $urandom_range(3, 0);
                    plan.post_delay_sec = $urandom_range(3, 0);
                    plan.min_trigger_sec = $urandom_range(4, 0);
                    plan.max_trigger_sec = $urandom_range(12, 0);
                    items = 200;
                end
                1: begin
                    // only frames at the same fine tick fit a one-tick window
                    plan.motion_threshold = '0;
                    plan.stable_frame_count = $urandom_range(2, 1);
                    plan.stable_window_ticks = 32'd1;
                    plan.pre_delay_sec = '0;
                    plan.post_delay_sec = '0;
                    plan.min_trigger_sec = '0;
                    plan.max_trigger_sec = '0;
                    items = 160;
                end
                2: begin
                    plan.motion_threshold = TimeMax;
                    plan.stable_frame_count = CountMax;
                    plan.stable_window_ticks = TimeMax;
                    plan.pre_delay_sec = TimeMax;
                    plan.post_delay_sec = TimeMax;
                    plan.min_trigger_sec = TimeMax;
                    plan.max_trigger_sec = TimeMax;
                    base = 32'hFFFF_FF80;
                    items = 60;
                end
                3: begin
                    plan.motion_threshold = $urandom_range(500, 0);
                    plan.stable_frame_count = $urandom_range(6, 2);
                    plan.stable_window_ticks = TimeMax;
                    plan.pre_delay_sec = $urandom_range(2, 0);
                    plan.post_delay_sec = $urandom_range(2, 0);
                    plan.min_trigger_sec = TimeMax;
                    plan.max_trigger_sec = $urandom_range(8, 0);
                    base = 32'hFFFF_FE00;
                    items = 200;
                end
                4: begin
                    plan.motion_threshold = $urandom;
                    plan.stable_frame_count = $urandom_range(3, 0);
                    plan.stable_window_ticks = $urandom;
                    plan.pre_delay_sec = $urandom_range(6, 0);
                    plan.post_delay_sec = $urandom_range(6, 0);
                    plan.min_trigger_sec = $urandom_range(6, 0);
                    plan.max_trigger_sec = $urandom_range(6, 0);
                    base = $urandom;
                    items = 120;
                end
                default: begin
                    plan.motion_threshold = $urandom;
                    plan.stable_frame_count = $urandom_range(5, 1);
                    plan.stable_window_ticks = $urandom_range(100000, 1);
                    plan.pre_delay_sec = $urandom_range(5, 0);
                    plan.post_delay_sec = $urandom_range(5, 0);
                    plan.min_trigger_sec = $urandom_range(5, 0);
                    plan.max_trigger_sec = $urandom_range(5, 0);
                    base = $urandom_range(100000, 0);
                    items = 200;
                end
            endcase
            run_phase(plan, base, items);
        end

        // back to the reset values with both sides running flat out
        plan.motion_threshold = RstMotionThreshold;
        plan.stable_frame_count = RstStableFrameCount;
        plan.stable_window_ticks = RstStableWindow;
        plan.pre_delay_sec = RstPreDelay;
        plan.post_delay_sec = RstPostDelay;
        plan.min_trigger_sec = RstMinTrigger;
        plan.max_trigger_sec = RstMaxTrigger;
        calm <= 1'b1;
        run_phase(plan, '0, 160);

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_motion_alarm_state_machine OK");
        end else begin
            $display("tb_motion_alarm_state_machine NOT OK");
        end
        $finish;
    end

endmodule
